[design/dq_pkg.sv]
// Shared types and constants for the bounded deque.
package dq_pkg;

  // Fixed widths of the channel fields and the capacity register.
  localparam int unsigned PUSH_BITS = 32;
  localparam int unsigned CAP_BITS  = 8;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 8'd128;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // latch the status code of the incoming item
    logic commit;  // perform the push or pop on the store and pointers
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } dp_flags_t;

endpackage

[design/dq_req_if.sv]
// Request channel: operation and push value with a valid/ready handshake.
interface dq_req_if;
  logic                                  valid;
  logic                                  ready;
  dq_pkg::op_e                           operation;
  logic signed [dq_pkg::PUSH_BITS-1:0]   push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

[design/dq_rsp_if.sv]
// Result channel: status and popped value with a valid/ready handshake.
interface dq_rsp_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  dq_pkg::status_e              status;
  logic signed [VALUE_BITS-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

[design/dq_ctrl.sv]
// Controller state machine: sequences accept, commit and result delivery.
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  dq_pkg::dp_flags_t  flags_i,
  output dq_pkg::ctrl_cmd_t  cmd_o
);

  dq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      dq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.take   = 1'b1;
          // A push commits unless full, a pop unless empty.
          cmd_o.commit = flags_i.is_pop ? !flags_i.empty : !flags_i.full;
          state_d      = dq_pkg::S_RESP;
        end
      end
      dq_pkg::S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/dq_dpath.sv]
// Datapath: circular element store, front index, count and capacity limit.
module dq_dpath #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dq_pkg::CAP_BITS-1:0]          cfg_wdata_i,
  input  dq_pkg::op_e                          operation_i,
  input  logic signed [dq_pkg::PUSH_BITS-1:0]  push_value_i,
  input  dq_pkg::ctrl_cmd_t                    cmd_i,
  output dq_pkg::dp_flags_t                    flags_o,
  output dq_pkg::status_e                      status_o,
  output logic signed [VALUE_BITS-1:0]         popped_value_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned LW = (CW > dq_pkg::CAP_BITS) ? CW : dq_pkg::CAP_BITS;

  logic [VALUE_BITS-1:0]       mem_q [DEPTH];
  logic [VALUE_BITS-1:0]       rd_q;
  logic [IW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic [dq_pkg::CAP_BITS-1:0] cap_q;
  dq_pkg::status_e             status_q, status_d;

  logic [LW-1:0]         limit;
  logic                  is_pop, is_front;
  logic [CW-1:0]         offset;
  logic [SW-1:0]         sum;
  logic [IW-1:0]         wrap_addr, front_dec, front_inc, addr;
  logic [VALUE_BITS-1:0] wr_value;

  // Capacity limit and queue flags.
  always_comb begin
    limit = (LW'(cap_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_q);
    is_pop   = (operation_i == dq_pkg::OP_POP_FRONT) ||
               (operation_i == dq_pkg::OP_POP_BACK);
    is_front = (operation_i == dq_pkg::OP_PUSH_FRONT) ||
               (operation_i == dq_pkg::OP_POP_FRONT);
    flags_o.is_pop = is_pop;
    flags_o.full   = LW'(count_q) >= limit;
    flags_o.empty  = count_q == '0;
  end

  // Slot addresses with wrap-around at DEPTH.
  always_comb begin
    if (is_front) begin
      offset = '0;
    end else if (is_pop) begin
      offset = count_q - CW'(1);
    end else begin
      offset = count_q;
    end
    sum       = SW'(front_q) + SW'(offset);
    wrap_addr = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);
    front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
    front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
    addr      = (operation_i == dq_pkg::OP_PUSH_FRONT) ? front_dec : wrap_addr;
    wr_value  = VALUE_BITS'(push_value_i);
  end

  // Pointer, count and status updates.
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    if (cmd_i.take) begin
      if (is_pop) begin
        status_d = flags_o.empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_POPPED;
      end else begin
        status_d = flags_o.full ? dq_pkg::ST_FULL : dq_pkg::ST_PUSHED;
      end
    end
    if (cmd_i.commit) begin
      case (operation_i)
        dq_pkg::OP_PUSH_FRONT: begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
        dq_pkg::OP_PUSH_BACK: begin
          count_d = count_q + CW'(1);
        end
        dq_pkg::OP_POP_FRONT: begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
        dq_pkg::OP_POP_BACK: begin
          count_d = count_q - CW'(1);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      cap_q    <= dq_pkg::CAP_RESET;
      status_q <= dq_pkg::ST_PUSHED;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Element store: one write or one registered read per item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (is_pop) begin
        rd_q <= mem_q[addr];
      end else begin
        mem_q[addr] <= wr_value;
      end
    end
  end

  // Result fields; the value is zero unless an element was removed.
  assign status_o       = status_q;
  assign popped_value_o = (status_q == dq_pkg::ST_POPPED) ? rd_q : '0;

endmodule

[design/bounded_deque_core.sv]
// Top level of the bounded double-ended queue.
//
//   Channel   Direction  Handshake          Payload
//   req       in         valid/ready        operation, push_value
//   rsp       out        valid/ready        status, popped_value
//   cfg       in         cfg_we_i           cfg_wdata_i (capacity)
//
// An item is taken in the idle state and its result is shown from the next cycle
// until taken. The controller takes no new item while a result is shown, so the
// block cannot take a new item before the last result is taken; the store and the
// pointers finish their work at the accepting edge. A stalled result holds the block.
// Reset empties the queue and sets the capacity to 128; the store is not cleared.
module bounded_deque_core #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dq_pkg::CAP_BITS-1:0] cfg_wdata_i,
  dq_req_if.sink                      req,
  dq_rsp_if.source                    rsp
);

  dq_pkg::ctrl_cmd_t cmd;
  dq_pkg::dp_flags_t flags;

  // Controller.
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // Datapath.
  dq_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (req.operation),
    .push_value_i   (req.push_value),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .status_o       (rsp.status),
    .popped_value_o (rsp.popped_value)
  );

endmodule

[sim/tb_bounded_deque_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_core: directed and random requests against a mirror queue.
module tb_bounded_deque_core;
  import dq_pkg::*;

  localparam int unsigned DEPTH         = 128;
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned IDX_BITS      = $clog2(DEPTH);
  localparam int          CLK_PERIOD    = 4;
  localparam int          RESET_CYCLES  = 6;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct {
    op_e                          op;
    logic signed [PUSH_BITS-1:0]  value;
    bit                           drain_first;
  } request_t;

  typedef struct {
    status_e                      status;
    logic signed [VALUE_BITS-1:0] popped;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  dq_req_if                             req_ch ();
  dq_rsp_if #(.VALUE_BITS(VALUE_BITS))  rsp_ch ();

  bounded_deque_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // Mirror of the queue contents, pointers and capacity register.
  logic signed [VALUE_BITS-1:0] mirror_store [DEPTH];
  logic [IDX_BITS-1:0]          mirror_front;
  logic [CAP_BITS-1:0]          mirror_count;
  logic [CAP_BITS-1:0]          mirror_cap;

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rsp_mode;
  int unsigned mode_left;
  int unsigned stall_left;
  int          quiet_cycles;
  int          mismatch_count;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Apply one request to the mirror queue and return the result it should give.
  function automatic outcome_t deque_apply(request_t r);
    outcome_t            res;
    logic [CAP_BITS-1:0] limit;
    logic [IDX_BITS-1:0] slot;
    limit      = (mirror_cap > CAP_BITS'(DEPTH)) ? CAP_BITS'(DEPTH) : mirror_cap;
    res.popped = '0;
    if (r.op == OP_PUSH_FRONT || r.op == OP_PUSH_BACK) begin
      if (mirror_count >= limit) begin
        res.status = ST_FULL;
      end else begin
        if (r.op == OP_PUSH_FRONT) begin
          mirror_front               = mirror_front - 1'b1;
          mirror_store[mirror_front] = r.value;
        end else begin
          slot               = mirror_front + mirror_count[IDX_BITS-1:0];
          mirror_store[slot] = r.value;
        end
        mirror_count = mirror_count + 1'b1;
        res.status   = ST_PUSHED;
      end
    end else if (mirror_count == '0) begin
      res.status = ST_EMPTY;
    end else begin
      if (r.op == OP_POP_FRONT) begin
        res.popped   = mirror_store[mirror_front];
        mirror_front = mirror_front + 1'b1;
      end else begin
        slot       = mirror_front + IDX_BITS'(mirror_count - 1'b1);
        res.popped = mirror_store[slot];
      end
      mirror_count = mirror_count - 1'b1;
      res.status   = ST_POPPED;
    end
    return res;
  endfunction

  // Push values lean on the extremes, all-ones and small numbers.
  function automatic logic signed [PUSH_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(PUSH_BITS - 1){1'b0}}};
      1: return {1'b0, {(PUSH_BITS - 1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return PUSH_BITS'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic queue_item(op_e op, logic signed [PUSH_BITS-1:0] value);
    request_t r;
    r.op          = op;
    r.value       = value;
    r.drain_first = 1'b0;
    request_q.push_back(r);
  endtask

  // Random requests; push_pct steers the queue toward full or toward empty.
  task automatic queue_random(int n, int push_pct);
    request_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        r.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        r.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      r.value       = rand_value();
      r.drain_first = ($urandom_range(0, 59) == 0) || (i == n / 2);
      request_q.push_back(r);
    end
  endtask

  // Checked at the falling edge, once the driver's updates from the rising edge have landed.
  task automatic wait_for_drain();
    while (request_q.size() != 0 || req_ch.valid || outcome_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The register is only written once the block has gone quiet.
  task automatic set_capacity(logic [CAP_BITS-1:0] cap);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= cap;
    mirror_cap  = cap;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  // Request driver: bursts of items with random gaps, some items wait for a drained queue.
  always @(posedge clk_i) begin : driver
    request_t            nxt;
    logic                start;
    logic                busy;
    request_t            taken;
    if (rst_ni) begin
      start = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        taken.op          = req_ch.operation;
        taken.value       = req_ch.push_value;
        taken.drain_first = 1'b0;
        outcome_q.push_back(deque_apply(taken));
      end
      busy = req_ch.valid && !req_ch.ready;
      if (!busy && request_q.size() != 0) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (burst_left != 0) begin
          if (!request_q[0].drain_first || outcome_q.size() == 0) begin
            nxt        = request_q.pop_front();
            start      = 1'b1;
            burst_left = burst_left - 1;
          end
        end else begin
          gap_left = gap_left - 1;
        end
      end
      if (!busy) begin
        req_ch.valid <= start;
        if (start) begin
          req_ch.operation  <= nxt.op;
          req_ch.push_value <= nxt.value;
        end
      end
    end
  end

  // Result monitor: compares each item with the oldest prediction and drives the stall pattern.
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    logic     nready;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          note_error($sformatf("unexpected result: status %0d value %0d",
                               rsp_ch.status, rsp_ch.popped_value));
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            note_error($sformatf("status: expected %0d, got %0d", want.status, rsp_ch.status));
          end
          if (rsp_ch.popped_value !== want.popped) begin
            note_error($sformatf("popped_value: expected %0d, got %0d",
                                 want.popped, rsp_ch.popped_value));
          end
        end
      end

      // Stall modes: always ready, short random stalls, or rare long stalls.
      if (mode_left == 0) begin
        rsp_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 250);
      end else begin
        mode_left = mode_left - 1;
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        nready     = 1'b0;
      end else begin
        nready = 1'b1;
        if (rsp_mode == 1 && $urandom_range(0, 1) == 0) begin
          stall_left = $urandom_range(1, 2);
        end else if (rsp_mode == 2 && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(4, 12);
        end
      end
      rsp_ch.ready <= nready;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_bounded_deque_core: done, errors");
        $finish;
      end
    end
  end

  // Reset, then directed cases, then random phases over several capacities.
  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_PUSH_FRONT;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    mirror_front      = '0;
    mirror_count      = '0;
    mirror_cap        = CAP_RESET;
    burst_left        = 0;
    gap_left          = 0;
    rsp_mode          = 0;
    mode_left         = 0;
    stall_left        = 0;
    quiet_cycles      = 0;
    mismatch_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small capacity: empty pops at both ends, extreme values, full at both ends.
    set_capacity(8'd3);
    queue_item(OP_POP_FRONT, $urandom());
    queue_item(OP_POP_BACK, $urandom());
    queue_item(OP_PUSH_FRONT, 32'sh8000_0000);
    queue_item(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    queue_item(OP_PUSH_FRONT, 32'sh0000_0000);
    queue_item(OP_PUSH_BACK, 32'shFFFF_FFFF);
    queue_item(OP_PUSH_FRONT, 32'sh0000_0001);
    queue_item(OP_POP_BACK, $urandom());
    queue_item(OP_POP_FRONT, $urandom());
    queue_item(OP_POP_BACK, $urandom());
    queue_item(OP_POP_FRONT, $urandom());
    queue_item(OP_PUSH_BACK, 32'sh5555_5555);
    queue_item(OP_PUSH_BACK, 32'shAAAA_AAAA);
    queue_item(OP_POP_FRONT, $urandom());
    queue_item(OP_POP_FRONT, $urandom());

    // Zero capacity takes nothing.
    set_capacity(8'd0);
    queue_item(OP_PUSH_FRONT, 32'sh0000_0007);
    queue_item(OP_PUSH_BACK, -32'sd7);
    queue_item(OP_POP_BACK, $urandom());

    // Capacity above the store size fills to the store size.
    set_capacity(8'd255);
    queue_random(190, 85);

    // Capacity lowered below the held count; pops must bring it down first.
    set_capacity(8'd5);
    queue_random(150, 25);
    set_capacity(8'd1);
    queue_random(80, 50);
    set_capacity(8'd128);
    queue_random(200, 65);
    set_capacity(8'd2);
    queue_random(80, 50);
    set_capacity(CAP_BITS'($urandom_range(3, 127)));
    queue_random(140, 55);
    set_capacity(8'd0);
    queue_random(25, 50);
    set_capacity(8'd129);
    queue_random(170, 35);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("tb_bounded_deque_core: done, clean");
    end else begin
      $display("tb_bounded_deque_core: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/dq_pkg.sv
design/dq_req_if.sv
design/dq_rsp_if.sv
design/dq_ctrl.sv
design/dq_dpath.sv
design/bounded_deque_core.sv
sim/tb_bounded_deque_core.sv
